[design/char_lcd_parallel_write_sequencer_unit_macros.svh]
// Assertion macros shared by the write sequencer modules.
// No dependencies; the assertion forms drop out when SYNTHESIS is defined.
`ifndef CHAR_LCD_PARALLEL_WRITE_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_PARALLEL_WRITE_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Implication that must hold at every clock edge outside reset.
`define LCDWS_ASSERT(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("lcdws assertion failed");
// Condition that must never be seen outside reset.
`define LCDWS_NEVER(label, clk_sig, rst_sig, cond) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("lcdws forbidden condition seen");
`else
`define LCDWS_ASSERT(label, clk_sig, rst_sig, prop)
`define LCDWS_NEVER(label, clk_sig, rst_sig, cond)
`endif

`endif

[design/lcdws_pkg.sv]
// Types, constants and lookup functions of the LCD write sequencer.
// No dependencies; used by every module of the block.
package lcdws_pkg;

  localparam int WAIT_BITS = 20;
  localparam int TICK_BITS = 16;
  localparam int CFG_BITS  = 20;
  localparam int IDX_BITS  = 3;

  localparam int JOB_DEPTH    = 4;
  localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_BITS = $clog2(JOB_DEPTH + 1);

  // Request kinds
  localparam logic [1:0] REQ_COMMAND = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_CURSOR  = 2'd2;
  localparam logic [1:0] REQ_INIT    = 2'd3;

  // Configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_ENABLE_HALF = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_SETUP       = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_POWERUP     = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_FIRST_INIT  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SHORT_INIT  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_CLEAR       = 3'd5;

  // Init sequence steps
  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_FS2   = 3'd1;
  localparam logic [2:0] STEP_FS3   = 3'd2;
  localparam logic [2:0] STEP_FUNC  = 3'd3;
  localparam logic [2:0] STEP_DISP  = 3'd4;
  localparam logic [2:0] STEP_CLEAR = 3'd5;
  localparam logic [2:0] STEP_LAST  = 3'd6;

  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic [7:0] data_byte;
  } job_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] enable_half_ticks;
    logic [TICK_BITS-1:0] setup_ticks;
    logic [WAIT_BITS-1:0] powerup_wait;
    logic [WAIT_BITS-1:0] first_init_wait;
    logic [WAIT_BITS-1:0] short_init_wait;
    logic [WAIT_BITS-1:0] clear_wait;
  } wait_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EN_HIGH,
    ST_EN_LOW,
    ST_GAP,
    ST_POST
  } bus_state_t;

  function automatic logic [7:0] line_base(input logic [2:0] line);
    logic [7:0] base;
    case (line)
      3'd2:    base = 8'h40;
      3'd3:    base = 8'h14;
      3'd4:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      STEP_FIRST, STEP_FS2, STEP_FS3: b = 8'h30;
      STEP_FUNC:                      b = 8'h38;
      STEP_DISP:                      b = 8'h0C;
      STEP_CLEAR:                     b = 8'h01;
      default:                        b = 8'h06;
    endcase
    return b;
  endfunction

  function automatic logic [WAIT_BITS-1:0] init_trail(input logic [2:0] step,
                                                      input wait_cfg_t cfg);
    logic [WAIT_BITS-1:0] w;
    unique case (step)
      STEP_FIRST:         w = cfg.first_init_wait;
      STEP_FS2, STEP_FS3: w = cfg.short_init_wait;
      STEP_CLEAR:         w = cfg.clear_wait;
      default:            w = '0;
    endcase
    return w;
  endfunction

endpackage

[design/lcdws_front.sv]
// Front end: decodes one request into a job for the bus sequencer.
// Depends on lcdws_pkg for the job type and address lookup.
module lcdws_front (
  input  logic [1:0]        req_type,
  input  logic [7:0]        byte_value,
  input  logic [2:0]        line_number,
  input  logic [5:0]        column_number,
  output lcdws_pkg::job_t   job
);

  logic [7:0] addr;

  // base + column - 1, wrapping at 8 bits
  assign addr = lcdws_pkg::line_base(line_number) + {2'b00, column_number} + 8'hFF;

  always_comb begin
    job = '0;
    unique case (req_type)
      lcdws_pkg::REQ_COMMAND: begin
        job.data_byte = byte_value;
      end
      lcdws_pkg::REQ_DATA: begin
        job.reg_select = 1'b1;
        job.data_byte  = byte_value;
      end
      lcdws_pkg::REQ_CURSOR: begin
        job.data_byte = 8'h80 | addr;
      end
      default: begin
        job.is_init = 1'b1;
      end
    endcase
  end

endmodule

[design/lcdws_fifo.sv]
// Short job queue between the front end and the bus sequencer.
// Depends on lcdws_pkg for the job type and depth constants.
`include "char_lcd_parallel_write_sequencer_unit_macros.svh"

module lcdws_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lcdws_pkg::job_t        wr_job,
  output logic                   full,
  input  logic                   pop,
  output lcdws_pkg::job_t        rd_job,
  output logic                   not_empty
);

  lcdws_pkg::job_t                        slots [lcdws_pkg::JOB_DEPTH];
  logic [lcdws_pkg::JOB_PTR_BITS-1:0]     wr_ptr;
  logic [lcdws_pkg::JOB_PTR_BITS-1:0]     rd_ptr;
  logic [lcdws_pkg::JOB_CNT_BITS-1:0]     count;

  localparam logic [lcdws_pkg::JOB_PTR_BITS-1:0] PTR_LAST =
    lcdws_pkg::JOB_PTR_BITS'(lcdws_pkg::JOB_DEPTH - 1);
  localparam logic [lcdws_pkg::JOB_CNT_BITS-1:0] CNT_FULL =
    lcdws_pkg::JOB_CNT_BITS'(lcdws_pkg::JOB_DEPTH);

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LCDWS_NEVER(a_fifo_over, clk, rst, count > CNT_FULL)
  `LCDWS_NEVER(a_fifo_pop_empty, clk, rst, pop && (count == '0))
  `LCDWS_NEVER(a_fifo_push_full, clk, rst, push && full)

endmodule

[design/lcdws_back.sv]
// Back end: times each bus write and posts it to the result register.
// Depends on lcdws_pkg for the job, timing and state types.
`include "char_lcd_parallel_write_sequencer_unit_macros.svh"

module lcdws_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  input  lcdws_pkg::job_t                  job,
  output logic                             job_pop,
  input  lcdws_pkg::wait_cfg_t             cfg,
  input  logic                             pop,
  output logic                             empty,
  output logic                             reg_select,
  output logic [7:0]                       data_byte,
  output logic [lcdws_pkg::WAIT_BITS-1:0]  lead_wait,
  output logic [lcdws_pkg::WAIT_BITS-1:0]  trail_wait,
  output logic                             last_write
);

  lcdws_pkg::bus_state_t            state, state_next;
  logic [lcdws_pkg::TICK_BITS-1:0]  cnt, cnt_next;
  logic [2:0]                       step, step_next;
  lcdws_pkg::job_t                  cur;
  logic                             out_valid;
  logic                             load_out;

  logic                             wr_rs;
  logic [7:0]                       wr_byte;
  logic [lcdws_pkg::WAIT_BITS-1:0]  wr_lead;
  logic [lcdws_pkg::WAIT_BITS-1:0]  wr_trail;
  logic                             wr_last;

  assign empty = !out_valid;

  always_comb begin
    wr_rs    = cur.is_init ? 1'b0 : cur.reg_select;
    wr_byte  = cur.is_init ? lcdws_pkg::init_byte(step) : cur.data_byte;
    wr_lead  = (cur.is_init && step == lcdws_pkg::STEP_FIRST) ? cfg.powerup_wait : '0;
    wr_trail = cur.is_init ? lcdws_pkg::init_trail(step, cfg) : '0;
    wr_last  = !cur.is_init || (step == lcdws_pkg::STEP_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcdws_pkg::ST_IDLE;
      cnt       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      step  <= step_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    if (load_out) begin
      reg_select <= wr_rs;
      data_byte  <= wr_byte;
      lead_wait  <= wr_lead;
      trail_wait <= wr_trail;
      last_write <= wr_last;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    job_pop    = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      lcdws_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          step_next  = lcdws_pkg::STEP_FIRST;
          cnt_next   = cfg.setup_ticks;
          state_next = lcdws_pkg::ST_SETUP;
        end
      end
      lcdws_pkg::ST_SETUP: begin
        if (cnt == '0) begin
          cnt_next   = cfg.enable_half_ticks;
          state_next = lcdws_pkg::ST_EN_HIGH;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      lcdws_pkg::ST_EN_HIGH: begin
        if (cnt == '0) begin
          cnt_next   = cfg.enable_half_ticks;
          state_next = lcdws_pkg::ST_EN_LOW;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      lcdws_pkg::ST_EN_LOW: begin
        if (cnt == '0) begin
          cnt_next   = cfg.setup_ticks;
          state_next = lcdws_pkg::ST_GAP;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      lcdws_pkg::ST_GAP: begin
        if (cnt == '0) begin
          state_next = lcdws_pkg::ST_POST;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      lcdws_pkg::ST_POST: begin
        // hold until the result register frees up
        if (!out_valid || pop) begin
          load_out = 1'b1;
          if (cur.is_init && step != lcdws_pkg::STEP_LAST) begin
            step_next  = step + 1'b1;
            cnt_next   = cfg.setup_ticks;
            state_next = lcdws_pkg::ST_SETUP;
          end else begin
            state_next = lcdws_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = lcdws_pkg::ST_IDLE;
      end
    endcase
  end

  `LCDWS_NEVER(a_back_step_range, clk, rst, step > lcdws_pkg::STEP_LAST)
  `LCDWS_ASSERT(a_back_take_idle, clk, rst, job_pop |-> job_valid && state == lcdws_pkg::ST_IDLE)
  `LCDWS_ASSERT(a_back_post_full, clk, rst,
    (state == lcdws_pkg::ST_POST && out_valid && !pop) |=> state == lcdws_pkg::ST_POST)

endmodule

[design/char_lcd_parallel_write_sequencer_unit.sv]
// Character LCD write sequencer: requests in, timed 8-bit bus writes out.
// Each bus write passes through the setup, enable-high, enable-low, gap and post
// states of the back-end timer, after an idle state that takes a new request;
// init yields 7 writes. Requests queue four deep ahead of the timer. Synchronous
// reset empties the job queue and the result register and restores the timing
// registers to their power-on values.
module char_lcd_parallel_write_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         req_type,
  input  logic [7:0]                         byte_value,
  input  logic [2:0]                         line_number,
  input  logic [5:0]                         column_number,
  output logic                               empty,
  input  logic                               pop,
  output logic                               reg_select,
  output logic [7:0]                         data_byte,
  output logic [lcdws_pkg::WAIT_BITS-1:0]    lead_wait,
  output logic [lcdws_pkg::WAIT_BITS-1:0]    trail_wait,
  output logic                               last_write,
  input  logic                               cfg_write,
  input  logic [lcdws_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [lcdws_pkg::CFG_BITS-1:0]     cfg_data
);

  lcdws_pkg::wait_cfg_t  cfg;
  lcdws_pkg::job_t       new_job;
  lcdws_pkg::job_t       head_job;
  logic                  job_valid;
  logic                  job_pop;
  logic                  accept;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_half_ticks <= 16'd1000;
      cfg.setup_ticks       <= 16'd2000;
      cfg.powerup_wait      <= 20'd80000;
      cfg.first_init_wait   <= 20'd80000;
      cfg.short_init_wait   <= 20'd20000;
      cfg.clear_wait        <= 20'd500000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lcdws_pkg::REG_ENABLE_HALF: cfg.enable_half_ticks <= cfg_data[15:0];
        lcdws_pkg::REG_SETUP:       cfg.setup_ticks       <= cfg_data[15:0];
        lcdws_pkg::REG_POWERUP:     cfg.powerup_wait      <= cfg_data[19:0];
        lcdws_pkg::REG_FIRST_INIT:  cfg.first_init_wait   <= cfg_data[19:0];
        lcdws_pkg::REG_SHORT_INIT:  cfg.short_init_wait   <= cfg_data[19:0];
        lcdws_pkg::REG_CLEAR:       cfg.clear_wait        <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  lcdws_front u_front (
    .req_type      (req_type),
    .byte_value    (byte_value),
    .line_number   (line_number),
    .column_number (column_number),
    .job           (new_job)
  );

  lcdws_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .wr_job    (new_job),
    .full      (full),
    .pop       (job_pop),
    .rd_job    (head_job),
    .not_empty (job_valid)
  );

  lcdws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (head_job),
    .job_pop    (job_pop),
    .cfg        (cfg),
    .pop        (pop),
    .empty      (empty),
    .reg_select (reg_select),
    .data_byte  (data_byte),
    .lead_wait  (lead_wait),
    .trail_wait (trail_wait),
    .last_write (last_write)
  );

endmodule

[verif/tb_char_lcd_parallel_write_sequencer_unit.sv]
`timescale 1ns / 1ps
// Testbench for the character LCD write sequencer: drives requests, predicts the bus writes,
// checks every result beat. Depends on lcdws_pkg and char_lcd_parallel_write_sequencer_unit.
module tb_char_lcd_parallel_write_sequencer_unit;

  localparam logic [lcdws_pkg::IDX_BITS-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [lcdws_pkg::IDX_BITS-1:0] REG_UNUSED_7 = 3'd7;

  localparam int POP_STEADY = 0;
  localparam int POP_HALF   = 1;
  localparam int POP_SPARSE = 2;
  localparam int POP_MOSTLY = 3;

  typedef struct packed {
    logic                            reg_select;
    logic [7:0]                      data_byte;
    logic [lcdws_pkg::WAIT_BITS-1:0] lead;
    logic [lcdws_pkg::WAIT_BITS-1:0] trail;
    logic                            last;
  } bus_write_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            push = 1'b0;
  logic                            full;
  logic [1:0]                      req_type = lcdws_pkg::REQ_COMMAND;
  logic [7:0]                      byte_value = 8'h00;
  logic [2:0]                      line_number = 3'd0;
  logic [5:0]                      column_number = 6'd0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic                            reg_select;
  logic [7:0]                      data_byte;
  logic [lcdws_pkg::WAIT_BITS-1:0] lead_wait;
  logic [lcdws_pkg::WAIT_BITS-1:0] trail_wait;
  logic                            last_write;
  logic                            cfg_write = 1'b0;
  logic [lcdws_pkg::IDX_BITS-1:0]  cfg_index = lcdws_pkg::REG_ENABLE_HALF;
  logic [lcdws_pkg::CFG_BITS-1:0]  cfg_data = '0;

  bus_write_t            pending_writes[$];
  lcdws_pkg::wait_cfg_t  timing_shadow;
  int                    err_count = 0;

  // sender pacing
  bit gaps_on = 1'b1;
  int burst_left = 0;

  // receiver pacing; hold_seq/hold_len are written by the test sequence only
  int hold_seq = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int pop_mode = POP_STEADY;
  int mode_left = 0;

  longint idle_cycles = 0;

  char_lcd_parallel_write_sequencer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .byte_value   (byte_value),
    .line_number  (line_number),
    .column_number(column_number),
    .empty        (empty),
    .pop          (pop),
    .reg_select   (reg_select),
    .data_byte    (data_byte),
    .lead_wait    (lead_wait),
    .trail_wait   (trail_wait),
    .last_write   (last_write),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bus_write_t bus_write(input logic rs, input logic [7:0] d,
                                           input logic [lcdws_pkg::WAIT_BITS-1:0] lead,
                                           input logic [lcdws_pkg::WAIT_BITS-1:0] trail,
                                           input logic last);
    bus_write_t w;
    w.reg_select = rs;
    w.data_byte  = d;
    w.lead       = lead;
    w.trail      = trail;
    w.last       = last;
    return w;
  endfunction

  // Queue up the bus writes one accepted request produces.
  function automatic void predict_bus_writes(input logic [1:0] kind, input logic [7:0] b,
                                             input logic [2:0] line, input logic [5:0] col);
    logic [7:0]                      base;
    logic [7:0]                      addr;
    logic [7:0]                      step_byte;
    logic [lcdws_pkg::WAIT_BITS-1:0] lead;
    logic [lcdws_pkg::WAIT_BITS-1:0] trail;
    case (kind)
      lcdws_pkg::REQ_COMMAND: pending_writes.push_back(bus_write(1'b0, b, '0, '0, 1'b1));
      lcdws_pkg::REQ_DATA:    pending_writes.push_back(bus_write(1'b1, b, '0, '0, 1'b1));
      lcdws_pkg::REQ_CURSOR: begin
        case (line)
          3'd2:    base = 8'h40;
          3'd3:    base = 8'h14;
          3'd4:    base = 8'h54;
          default: base = 8'h00;
        endcase
        // one-based column, wraps at 8 bits
        addr = base + {2'b00, col} - 8'd1;
        pending_writes.push_back(bus_write(1'b0, 8'h80 | addr, '0, '0, 1'b1));
      end
      default: begin
        for (int k = 0; k < 7; k++) begin
          case (k)
            0, 1, 2: step_byte = 8'h30;
            3:       step_byte = 8'h38;
            4:       step_byte = 8'h0C;
            5:       step_byte = 8'h01;
            default: step_byte = 8'h06;
          endcase
          lead = (k == 0) ? timing_shadow.powerup_wait : '0;
          case (k)
            0:       trail = timing_shadow.first_init_wait;
            1, 2:    trail = timing_shadow.short_init_wait;
            5:       trail = timing_shadow.clear_wait;
            default: trail = '0;
          endcase
          pending_writes.push_back(bus_write(1'b0, step_byte, lead, trail, k == 6));
        end
      end
    endcase
  endfunction

  function automatic longint write_cycles();
    return 2 * longint'(timing_shadow.setup_ticks) + 2 * longint'(timing_shadow.enable_half_ticks)
           + 6;
  endfunction

  function automatic longint idle_budget();
    return 16 * write_cycles() + longint'(timing_shadow.powerup_wait)
           + longint'(timing_shadow.first_init_wait) + 2 * longint'(timing_shadow.short_init_wait)
           + longint'(timing_shadow.clear_wait) + 20000;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got 0x%0h want 0x%0h", what, got, want);
    err_count++;
  endtask

  // Leaves cfg_write high; the caller drops it after its last write.
  task automatic write_reg(input logic [lcdws_pkg::IDX_BITS-1:0] idx,
                           input logic [lcdws_pkg::CFG_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      lcdws_pkg::REG_ENABLE_HALF:
        timing_shadow.enable_half_ticks = value[lcdws_pkg::TICK_BITS-1:0];
      lcdws_pkg::REG_SETUP:
        timing_shadow.setup_ticks       = value[lcdws_pkg::TICK_BITS-1:0];
      lcdws_pkg::REG_POWERUP:
        timing_shadow.powerup_wait      = value[lcdws_pkg::WAIT_BITS-1:0];
      lcdws_pkg::REG_FIRST_INIT:
        timing_shadow.first_init_wait   = value[lcdws_pkg::WAIT_BITS-1:0];
      lcdws_pkg::REG_SHORT_INIT:
        timing_shadow.short_init_wait   = value[lcdws_pkg::WAIT_BITS-1:0];
      lcdws_pkg::REG_CLEAR:
        timing_shadow.clear_wait        = value[lcdws_pkg::WAIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [lcdws_pkg::CFG_BITS-1:0] en,
                             input logic [lcdws_pkg::CFG_BITS-1:0] setup,
                             input logic [lcdws_pkg::CFG_BITS-1:0] pu,
                             input logic [lcdws_pkg::CFG_BITS-1:0] fi,
                             input logic [lcdws_pkg::CFG_BITS-1:0] sh,
                             input logic [lcdws_pkg::CFG_BITS-1:0] cl);
    write_reg(lcdws_pkg::REG_ENABLE_HALF, en);
    write_reg(lcdws_pkg::REG_SETUP, setup);
    write_reg(lcdws_pkg::REG_POWERUP, pu);
    write_reg(lcdws_pkg::REG_FIRST_INIT, fi);
    write_reg(lcdws_pkg::REG_SHORT_INIT, sh);
    write_reg(lcdws_pkg::REG_CLEAR, cl);
    cfg_write <= 1'b0;
  endtask

  task automatic send_req(input logic [1:0] kind, input logic [7:0] b, input logic [2:0] line,
                          input logic [5:0] col);
    int gap;
    push          <= 1'b1;
    req_type      <= kind;
    byte_value    <= b;
    line_number   <= line;
    column_number <= col;
    do @(posedge clk); while (full);
    predict_bus_writes(kind, b, line, col);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 10);
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_random_req();
    int pick;
    logic [1:0] kind;
    pick = $urandom_range(0, 9);
    if (pick < 3) kind = lcdws_pkg::REQ_COMMAND;
    else if (pick < 6) kind = lcdws_pkg::REQ_DATA;
    else if (pick < 9) kind = lcdws_pkg::REQ_CURSOR;
    else kind = lcdws_pkg::REQ_INIT;
    send_req(kind, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
             6'($urandom_range(0, 63)));
  endtask

  // Drain every expected beat, then let the current write run out.
  task automatic wait_bus_idle();
    push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (int'(write_cycles()) + 10) @(posedge clk);
  endtask

  task automatic test_reset_timing();
    send_req(lcdws_pkg::REQ_INIT, 8'h00, 3'd0, 6'd0);
    send_req(lcdws_pkg::REQ_COMMAND, 8'h00, 3'd0, 6'd0);
    wait_bus_idle();
  endtask

  task automatic test_direct_bytes();
    load_timing(1, 0, 0, 0, 0, 0);
    send_req(lcdws_pkg::REQ_COMMAND, 8'hFF, 3'd0, 6'd0);
    send_req(lcdws_pkg::REQ_DATA, 8'h00, 3'd0, 6'd0);
    send_req(lcdws_pkg::REQ_DATA, 8'hFF, 3'd0, 6'd0);
    // line and column must not leak into plain bytes
    send_req(lcdws_pkg::REQ_COMMAND, 8'h5A, 3'd7, 6'd63);
    send_req(lcdws_pkg::REQ_DATA, 8'hA5, 3'd3, 6'd20);
    wait_bus_idle();
  endtask

  task automatic test_cursor_moves();
    for (int line = 0; line < 8; line++) begin
      send_req(lcdws_pkg::REQ_CURSOR, 8'($urandom_range(0, 255)), 3'(line), 6'd1);
    end
    send_req(lcdws_pkg::REQ_CURSOR, 8'hFF, 3'd1, 6'd0);
    send_req(lcdws_pkg::REQ_CURSOR, 8'h00, 3'd4, 6'd63);
    send_req(lcdws_pkg::REQ_CURSOR, 8'h3C, 3'd2, 6'd42);
    wait_bus_idle();
  endtask

  task automatic test_init_waits();
    load_timing(1, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_req(lcdws_pkg::REQ_INIT, 8'hFF, 3'd7, 6'd63);
    wait_bus_idle();
    load_timing(2, 1, 20'h5A5A5, 20'hA5A5A, 20'h00001, 20'h80000);
    send_req(lcdws_pkg::REQ_INIT, 8'h00, 3'd0, 6'd0);
    wait_bus_idle();
  endtask

  task automatic test_timing_extremes();
    load_timing(16'hFFFF, 0, 0, 0, 0, 0);
    send_req(lcdws_pkg::REQ_COMMAND, 8'h81, 3'd0, 6'd0);
    wait_bus_idle();
    load_timing(1, 16'hFFFF, 0, 0, 0, 0);
    send_req(lcdws_pkg::REQ_DATA, 8'h7E, 3'd0, 6'd0);
    wait_bus_idle();
    // drop the upper bits of 16-bit registers; spare indexes change nothing
    write_reg(lcdws_pkg::REG_ENABLE_HALF, 20'hF0002);
    write_reg(lcdws_pkg::REG_SETUP, 20'hE0001);
    write_reg(REG_UNUSED_6, 20'($urandom_range(0, 20'hFFFFF)));
    write_reg(REG_UNUSED_7, 20'($urandom_range(0, 20'hFFFFF)));
    cfg_write <= 1'b0;
    send_req(lcdws_pkg::REQ_INIT, 8'h11, 3'd5, 6'd9);
    wait_bus_idle();
  endtask

  task automatic test_backpressure();
    load_timing(1, 0, 20'($urandom_range(0, 4095)), 20'($urandom_range(0, 4095)),
                20'($urandom_range(0, 4095)), 20'($urandom_range(0, 4095)));
    gaps_on = 1'b0;
    hold_len = 4000;
    hold_seq++;
    repeat (24) send_random_req();
    gaps_on = 1'b1;
    wait_bus_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      load_timing(20'($urandom_range(1, 6)), 20'($urandom_range(0, 5)),
                  20'($urandom_range(0, 4095)), 20'($urandom_range(0, 4095)),
                  20'($urandom_range(0, 4095)), 20'($urandom_range(0, 4095)));
      gaps_on = (phase != 1);
      repeat (14) send_random_req();
      wait_bus_idle();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    timing_shadow.enable_half_ticks = 16'd1000;
    timing_shadow.setup_ticks       = 16'd2000;
    timing_shadow.powerup_wait      = 20'd80000;
    timing_shadow.first_init_wait   = 20'd80000;
    timing_shadow.short_init_wait   = 20'd20000;
    timing_shadow.clear_wait        = 20'd500000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_timing();
    test_direct_bytes();
    test_cursor_moves();
    test_init_waits();
    test_timing_extremes();
    test_backpressure();
    test_random_traffic();
    if (err_count == 0 && pending_writes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: long hold when asked, otherwise a drifting pop pattern.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          pop_mode = $urandom_range(POP_STEADY, POP_MOSTLY);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (pop_mode)
          POP_STEADY: pop <= 1'b1;
          POP_HALF:   pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:    pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    bus_write_t want;
    if (!rst && pop && !empty) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected bus write, data_byte", longint'(data_byte), 0);
      end else begin
        want = pending_writes.pop_front();
        if (reg_select !== want.reg_select)
          report_mismatch("reg_select", longint'(reg_select), longint'(want.reg_select));
        if (data_byte !== want.data_byte)
          report_mismatch("data_byte", longint'(data_byte), longint'(want.data_byte));
        if (lead_wait !== want.lead)
          report_mismatch("lead_wait", longint'(lead_wait), longint'(want.lead));
        if (trail_wait !== want.trail)
          report_mismatch("trail_wait", longint'(trail_wait), longint'(want.trail));
        if (last_write !== want.last)
          report_mismatch("last_write", longint'(last_write), longint'(want.last));
      end
    end
  end

  // Watchdog: too long without any accepted request, result beat or register write.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((push && !full) || (pop && !empty) || cfg_write) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles > idle_budget()) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

[sim.f]
+incdir+design
design/lcdws_pkg.sv
design/lcdws_front.sv
design/lcdws_fifo.sv
design/lcdws_back.sv
design/char_lcd_parallel_write_sequencer_unit.sv
verif/tb_char_lcd_parallel_write_sequencer_unit.sv
